### design/psd_pkg.sv
// ---------------------------------------------------------------------------
// psd_pkg: shared constants for the steering pid drive
// register indexes, mode codes, direction codes and fixed sizes
// ---------------------------------------------------------------------------
package psd_pkg;
    localparam logic [1:0] REG_GAIN_P = 2'd0;
    localparam logic [1:0] REG_GAIN_I = 2'd1;
    localparam logic [1:0] REG_GAIN_D = 2'd2;
    localparam logic [1:0] REG_DEAD_BAND = 2'd3;

    localparam logic [1:0] MODE_MANUAL = 2'd1;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT = 2'd2;

    // duty ceiling and the used bits of target and position (at most 10)
    localparam int PWM_MAX = 255;
    localparam int POSITION_BITS = 10;
endpackage

### design/psd_serial_mul.sv
// ---------------------------------------------------------------------------
// psd_serial_mul: bit-serial unsigned multiplier
// shift-add, one multiplier bit per cycle
// ---------------------------------------------------------------------------
module psd_serial_mul #(
    parameter int A_W = 48,
    parameter int B_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic                 o_done,
    output logic [A_W+B_W-1:0]   o_prod
);
    localparam int CW = $clog2(B_W + 1);
    logic [A_W+B_W-1:0] r_acc, r_a;
    logic [B_W-1:0]     r_b;
    logic [CW-1:0]      r_cnt;
    logic               r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(B_W);
                r_acc  <= '0;
                r_a    <= {{B_W{1'b0}}, i_a};
                r_b    <= i_b;
            end else if (r_busy) begin
                if (r_b[0]) r_acc <= r_acc + r_a;
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### design/psd_serial_div.sv
// ---------------------------------------------------------------------------
// psd_serial_div: restoring unsigned divider
// one quotient bit per cycle
// ---------------------------------------------------------------------------
module psd_serial_div #(
    parameter int N_W = 64,
    parameter int D_W = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [N_W-1:0]  i_num,
    input  logic [D_W-1:0]  i_den,
    output logic            o_done,
    output logic [N_W-1:0]  o_quo
);
    localparam int CW = $clog2(N_W + 1);
    logic [N_W-1:0] r_q;
    logic [D_W:0]   r_rem;
    logic [D_W-1:0] r_den;
    logic [CW-1:0]  r_cnt;
    logic           r_busy, r_done;
    logic [D_W:0]   n_shift;

    assign n_shift = {r_rem[D_W-1:0], r_q[N_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N_W);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem <= n_shift - {1'b0, r_den};
                    r_q   <= {r_q[N_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q   <= {r_q[N_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

### design/pid_steering_hbridge_drive.sv
// ---------------------------------------------------------------------------
// pid_steering_hbridge_drive: steering pid with deadband and h-bridge duties
// one result item per control tick item
// ---------------------------------------------------------------------------
// A tick that is not a manual-mode tick on a good link gives its zero-drive
// result in the cycle after it is accepted. A pid tick runs through a
// sequencer sharing one bit-serial multiplier (16 multiplier bits) and one
// restoring divider (72 quotient bits): e*dt as two passes over the halves
// of dt, gain_i*|I|, /1000, |de|*1000, *gain_d, /dt, gain_p*|e| and an
// output state. The result waits in an output register; the next tick is
// accepted once that result is taken.
module pid_steering_hbridge_drive (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: target[9:0], position[19:10], now_ms[51:20], zero pad to 56
    input  logic [55:0] s_axis_tdata,
    // tuser: mode[1:0], link_good[2]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: right_drive[7:0], left_drive[15:8], last_error_out[26:16], pad
    output logic [31:0] m_axis_tdata,
    // tuser: direction[1:0]
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int PB = psd_pkg::POSITION_BITS;
    localparam logic signed [47:0] INT_LIM = 48'sh7FFF_FFFF_FFFF;
    localparam logic [71:0] ICAP = 72'd1 << 40;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0, S_MEDT = 4'd1, S_WEDT = 4'd2,
        S_MI = 4'd3, S_WMI = 4'd4, S_DI = 4'd5, S_WDI = 4'd6, S_MD1 = 4'd7,
        S_WMD1 = 4'd8, S_MD2 = 4'd9, S_WMD2 = 4'd10, S_DD = 4'd11,
        S_WDD = 4'd12, S_MP = 4'd13, S_WMP = 4'd14, S_OUT = 4'd15;

    logic [3:0]  r_st;
    logic [15:0] r_gp, r_gi, r_gd;
    logic [9:0]  r_db;
    logic signed [47:0] r_integ;
    logic signed [10:0] r_perr, r_e;
    logic signed [11:0] r_de;
    logic [31:0] r_ptime, r_now, r_dt;
    logic [71:0] r_iterm, r_dterm, r_pterm;
    logic        r_ovalid;
    logic [7:0]  r_right, r_left;
    logic [1:0]  r_dir;
    logic [10:0] r_eout;

    logic [10:0] n_tgt, n_pos;
    assign n_tgt = 11'(s_axis_tdata[PB-1:0]);
    assign n_pos = 11'(s_axis_tdata[10+PB-1:10]);

    // shared multiplier and divider
    logic        mul_start, mul_done, div_start, div_done;
    logic [47:0] mul_a;
    logic [15:0] mul_b;
    logic [63:0] mul_p;
    logic [71:0] div_n;
    logic [31:0] div_d;
    logic [71:0] div_q;

    psd_serial_mul #(.A_W(48), .B_W(16)) u_mul (
        .i_clk, .i_rst_n, .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_prod(mul_p));
    psd_serial_div #(.N_W(72), .D_W(32)) u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(div_n), .i_den(div_d),
        .o_done(div_done), .o_quo(div_q));

    // e*dt is done as two 16-bit halves of dt: low half first, high half via
    // a second pass tracked by r_hi
    logic        r_hi;
    logic [63:0] r_edt;
    logic signed [49:0] n_int;
    logic signed [49:0] n_edt_s;
    logic signed [47:0] n_integ;

    assign n_edt_s = r_e[10] ? -$signed({1'b0, r_edt[48:0]}) : $signed({1'b0, r_edt[48:0]});
    assign n_int   = 50'(r_integ) + n_edt_s;
    // saturated integral after adding e*dt
    assign n_integ = (n_int > 50'(INT_LIM)) ? INT_LIM
                   : (n_int < -50'(INT_LIM)) ? -INT_LIM : 48'(n_int);

    logic [10:0] abs_e;
    logic [11:0] abs_de;
    logic [47:0] abs_i;
    assign abs_e  = r_e[10] ? 11'(-r_e) : r_e;
    assign abs_de = r_de[11] ? 12'(-r_de) : r_de;
    assign abs_i  = n_integ[47] ? 48'(-n_integ) : n_integ;

    always_comb begin
        mul_start = 1'b0; mul_a = '0; mul_b = '0;
        div_start = 1'b0; div_n = '0; div_d = 32'd1;
        case (r_st)
            S_MEDT: begin
                mul_start = 1'b1; mul_a = 48'(abs_e); mul_b = r_dt[15:0];
            end
            S_MI: begin mul_start = 1'b1; mul_a = abs_i; mul_b = r_gi; end
            S_DI: begin div_start = 1'b1; div_n = 72'(mul_p); div_d = 32'd1000; end
            S_MD1: begin mul_start = 1'b1; mul_a = 48'(abs_de); mul_b = 16'd1000; end
            S_MD2: begin mul_start = 1'b1; mul_a = mul_p[47:0]; mul_b = r_gd; end
            S_DD: begin div_start = 1'b1; div_n = 72'(mul_p); div_d = r_dt; end
            S_MP: begin mul_start = 1'b1; mul_a = 48'(abs_e); mul_b = r_gp; end
            default: ;
        endcase
    end

    logic signed [73:0] n_sum;
    logic [73:0] n_mag;
    logic [7:0]  n_duty;

    assign n_sum = $signed({{2{r_pterm[71]}}, r_pterm})
                 + $signed({{2{r_iterm[71]}}, r_iterm})
                 + $signed({{2{r_dterm[71]}}, r_dterm});
    assign n_mag = n_sum[73] ? 74'(-n_sum) : n_sum;
    assign n_duty = (n_mag[73:8] > 66'(psd_pkg::PWM_MAX)) ? 8'(psd_pkg::PWM_MAX)
                  : n_mag[15:8];

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ovalid <= 1'b0;
            r_gp <= 16'd256; r_gi <= '0; r_gd <= '0; r_db <= 10'd10;
            r_integ <= '0; r_perr <= '0; r_ptime <= '0; r_hi <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    psd_pkg::REG_GAIN_P: r_gp <= i_cfg_data;
                    psd_pkg::REG_GAIN_I: r_gi <= i_cfg_data;
                    psd_pkg::REG_GAIN_D: r_gd <= i_cfg_data;
                    psd_pkg::REG_DEAD_BAND: r_db <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (s_acc) begin
                    if (s_axis_tuser[2] && s_axis_tuser[1:0] == psd_pkg::MODE_MANUAL) begin
                        r_e   <= 11'(n_tgt - n_pos);
                        r_de  <= 12'(n_tgt) - 12'(n_pos) - 12'(r_perr);
                        r_now <= s_axis_tdata[51:20];
                        r_dt  <= (s_axis_tdata[51:20] == r_ptime) ? 32'd1
                                 : s_axis_tdata[51:20] - r_ptime;
                        r_hi  <= 1'b0;
                        r_st  <= S_MEDT;
                    end else begin
                        r_right <= '0; r_left <= '0; r_dir <= psd_pkg::DIR_STOP;
                        r_eout <= r_perr; r_ovalid <= 1'b1;
                    end
                end
                S_MEDT: r_st <= S_WEDT;
                S_WEDT: if (mul_done) begin
                    if (!r_hi) begin
                        r_edt <= mul_p;
                        r_hi  <= 1'b1;
                        r_dt  <= {r_dt[15:0], r_dt[31:16]};
                        r_st  <= S_MEDT;
                    end else begin
                        r_edt <= 64'(r_edt) + (mul_p << 16);
                        r_dt  <= {r_dt[15:0], r_dt[31:16]};
                        r_st  <= S_MI;
                        r_hi  <= 1'b0;
                    end
                end
                S_MI: begin
                    r_integ <= n_integ;
                    r_st <= S_WMI;
                end
                S_WMI: if (mul_done) r_st <= S_DI;
                S_DI: r_st <= S_WDI;
                S_WDI: if (div_done) begin
                    r_iterm <= (div_q > ICAP) ? ICAP : div_q;
                    r_st <= S_MD1;
                end
                S_MD1: begin
                    if (r_integ[47]) r_iterm <= 72'(-r_iterm);
                    r_st <= S_WMD1;
                end
                S_WMD1: if (mul_done) r_st <= S_MD2;
                S_MD2: r_st <= S_WMD2;
                S_WMD2: if (mul_done) r_st <= S_DD;
                S_DD: r_st <= S_WDD;
                S_WDD: if (div_done) begin
                    r_dterm <= r_de[11] ? 72'(-div_q) : div_q;
                    r_st <= S_MP;
                end
                S_MP: r_st <= S_WMP;
                S_WMP: if (mul_done) begin
                    r_pterm <= r_e[10] ? 72'(-{8'd0, mul_p}) : 72'(mul_p);
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_perr <= r_e; r_ptime <= r_now; r_eout <= r_e;
                    if (abs_e <= 11'(r_db)) begin
                        r_right <= '0; r_left <= '0; r_dir <= psd_pkg::DIR_STOP;
                    end else if (!n_sum[73] && n_sum != 74'sd0) begin
                        r_right <= n_duty; r_left <= '0; r_dir <= psd_pkg::DIR_RIGHT;
                    end else begin
                        r_right <= '0; r_left <= n_duty; r_dir <= psd_pkg::DIR_LEFT;
                    end
                    r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_eout, r_left, r_right};
    assign m_axis_tuser  = r_dir;

    // a pending result blocks new input
    a_no_acc_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready) else $error("accept while result pending");
    // no drive while the direction is stop
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_dir == psd_pkg::DIR_STOP) |-> (r_right == 8'd0 && r_left == 8'd0))
        else $error("drive while stopped");
    // integral stays inside its limit
    a_integ_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integ != 48'sh8000_0000_0000) else $error("integral out of range");
endmodule
